@@ src/sha384_pkg.sv @@
// shared types, constants and round functions for the sha-384 stream hasher
// depends on nothing; used by every module in src
package sha384_pkg;

   localparam int unsigned WORD_W     = 64;
   localparam int unsigned SCHED_LEN  = 16;
   localparam int unsigned CHAIN_LEN  = 8;
   localparam int unsigned ROUNDS     = 80;

   localparam logic [6:0] FILL_LAST   = 7'd127;
   localparam logic [6:0] LEN_AT      = 7'd112;
   localparam logic [6:0] ROUND_LAST  = 7'd79;
   localparam logic [2:0] DIGEST_LAST = 3'd5;
   localparam logic [3:0] LEN_LAST    = 4'd15;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [63:0] START_VALUE [CHAIN_LEN] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [63:0] ROUND_K [ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic        word_last;
   } rsp_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_PAD,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   typedef struct packed {
      logic         push;
      byte_src_type src;
      logic         count_bits;
      logic [2:0]   len_sel;
      logic         init;
      logic         round;
      logic [6:0]   rnd;
      logic         add;
      logic         clear;
      logic         emit;
      logic [2:0]   out_idx;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [6:0] fill;
   } status_type;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [63:0] sched_sig0(input logic [63:0] x);
      sched_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] sched_sig1(input logic [63:0] x);
      sched_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] big_sig0(input logic [63:0] x);
      big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sig1(input logic [63:0] x);
      big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

endpackage

@@ src/sha384_ctrl.sv @@
// sequencer for byte intake, padding, the round loop and digest output
// depends on sha384_pkg; drives the command struct of sha384_dp
module sha384_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   byte_valid,
   input  logic                   message_end,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sha384_pkg::status_type status,
   output sha384_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LENGTH,
      ST_INIT,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type  state_ff, ret_ff;
   logic [6:0] rnd_ff;
   logic [3:0] len_cnt_ff;
   logic [2:0] out_cnt_ff;
   logic       rsp_valid_ff;
   logic       take;
   logic       full_push;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign full_push = cmd.push && (status.fill == sha384_pkg::FILL_LAST);

   always_comb begin
      cmd         = '0;
      cmd.src     = sha384_pkg::SRC_ZERO;
      cmd.rnd     = rnd_ff;
      cmd.len_sel = len_cnt_ff[2:0];
      cmd.out_idx = out_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && byte_valid) begin
               cmd.push       = 1'b1;
               cmd.src        = sha384_pkg::SRC_INPUT;
               cmd.count_bits = 1'b1;
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            cmd.src  = sha384_pkg::SRC_PAD;
         end
         ST_ZERO: begin
            cmd.push = (status.fill != sha384_pkg::LEN_AT);
         end
         ST_LENGTH: begin
            cmd.push = 1'b1;
            cmd.src  = len_cnt_ff[3] ? sha384_pkg::SRC_LENGTH : sha384_pkg::SRC_ZERO;
         end
         ST_INIT:  cmd.init  = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_ADD:   cmd.add   = 1'b1;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit  = 1'b1;
               cmd.last  = (out_cnt_ff == sha384_pkg::DIGEST_LAST);
               cmd.clear = (out_cnt_ff == sha384_pkg::DIGEST_LAST);
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rnd_ff       <= '0;
         len_cnt_ff   <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  if (full_push) begin
                     state_ff <= ST_INIT;
                     ret_ff   <= message_end ? ST_PAD : ST_IDLE;
                  end else if (message_end) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               if (full_push) begin
                  state_ff <= ST_INIT;
                  ret_ff   <= ST_ZERO;
               end else begin
                  state_ff <= ST_ZERO;
               end
            end
            ST_ZERO: begin
               if (!cmd.push) begin
                  state_ff   <= ST_LENGTH;
                  len_cnt_ff <= '0;
               end else if (full_push) begin
                  state_ff <= ST_INIT;
                  ret_ff   <= ST_ZERO;
               end
            end
            ST_LENGTH: begin
               len_cnt_ff <= len_cnt_ff + 4'd1;
               if (len_cnt_ff == sha384_pkg::LEN_LAST) begin
                  state_ff <= ST_INIT;
                  ret_ff   <= ST_OUT;
               end
            end
            ST_INIT: begin
               rnd_ff   <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == sha384_pkg::ROUND_LAST) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               state_ff   <= ret_ff;
               out_cnt_ff <= '0;
            end
            ST_OUT: begin
               if (cmd.emit) begin
                  out_cnt_ff <= out_cnt_ff + 3'd1;
                  if (cmd.last) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ src/sha384_dp.sv @@
// datapath: byte packer, 16-word schedule window, round registers, chain and bit count
// depends on sha384_pkg; steered by sha384_ctrl
module sha384_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             data_byte,
   input  sha384_pkg::cmd_type    cmd,
   output sha384_pkg::status_type status,
   output sha384_pkg::rsp_type    rsp_data
);

   logic [63:0] word_ff;
   logic [6:0]  fill_ff;
   logic [63:0] bitcnt_ff;
   logic [63:0] chain_ff [sha384_pkg::CHAIN_LEN];
   logic [63:0] v_ff     [sha384_pkg::CHAIN_LEN];
   logic [63:0] w_ff     [sha384_pkg::SCHED_LEN];
   sha384_pkg::rsp_type rsp_ff;

   logic [7:0]  byte_in;
   logic [63:0] word_in;
   logic        w_shift;
   logic [63:0] w_tail_in;
   logic [63:0] w_next;
   logic [63:0] ch, mj, t1, t2;

   assign status.fill = fill_ff;
   assign rsp_data    = rsp_ff;

   always_comb begin
      case (cmd.src)
         sha384_pkg::SRC_INPUT:  byte_in = data_byte;
         sha384_pkg::SRC_PAD:    byte_in = sha384_pkg::PAD_BYTE;
         sha384_pkg::SRC_LENGTH: byte_in = bitcnt_ff[{~cmd.len_sel, 3'b000} +: 8];
         default:                byte_in = 8'h00;
      endcase
   end

   assign word_in   = {word_ff[55:0], byte_in};
   assign w_next    = w_ff[0] + sha384_pkg::sched_sig0(w_ff[1]) + w_ff[9]
                      + sha384_pkg::sched_sig1(w_ff[14]);
   assign w_shift   = cmd.round || (cmd.push && (fill_ff[2:0] == 3'b111));
   assign w_tail_in = cmd.round ? w_next : word_in;

   assign ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1 = v_ff[7] + sha384_pkg::big_sig1(v_ff[4]) + ch
               + sha384_pkg::ROUND_K[cmd.rnd] + w_ff[0];
   assign t2 = sha384_pkg::big_sig0(v_ff[0]) + mj;

   // message state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         bitcnt_ff <= '0;
         chain_ff  <= sha384_pkg::START_VALUE;
      end else begin
         if (cmd.push) fill_ff <= fill_ff + 7'd1;
         if (cmd.push && cmd.count_bits) bitcnt_ff <= bitcnt_ff + sha384_pkg::BITS_PER_BYTE;
         if (cmd.add) begin
            for (int i = 0; i < sha384_pkg::CHAIN_LEN; i++) begin
               chain_ff[i] <= chain_ff[i] + v_ff[i];
            end
         end
         if (cmd.clear) begin
            fill_ff   <= '0;
            bitcnt_ff <= '0;
            chain_ff  <= sha384_pkg::START_VALUE;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.push) word_ff <= word_in;
      if (w_shift) begin
         for (int i = 0; i < sha384_pkg::SCHED_LEN - 1; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[sha384_pkg::SCHED_LEN - 1] <= w_tail_in;
      end
      if (cmd.init) v_ff <= chain_ff;
      if (cmd.round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (cmd.emit) begin
         rsp_ff.digest_word <= chain_ff[cmd.out_idx];
         rsp_ff.word_last   <= cmd.last;
      end
   end

endmodule

@@ src/sha384_stream_hasher.sv @@
// top level of the sha-384 stream hasher
// depends on sha384_pkg, sha384_ctrl and sha384_dp
//
// req channel: one item per handshake, carrying data_byte, byte_valid and
// message_end. an item with byte_valid takes one message byte; an item with
// message_end closes the message after its byte and starts the digest.
// rsp channel: six 64-bit digest words, most significant first, word_last
// marks the sixth.
// a byte item that neither completes a 128-byte block nor closes the message
// leaves req_ready high. the byte that completes a block starts the
// compression, which holds req_ready low through the copy, 80 rounds on one
// shared round unit and the chain add. closing a message pads one byte per
// cycle, pausing for a compression when a block fills, up to the length
// field, writes the 16 length bytes, and runs one or two compressions; the
// digest words follow, one word per cycle while the receiver takes them.
// rsp words sit in an output register; a stalled receiver holds the digest
// engine in its output phase, and the next message may begin while the last
// word still waits to be taken.
// synchronous reset loads the initial hash values and clears the byte and bit
// counters; the block is ready as soon as reset falls. the same state is
// restored after each digest.
module sha384_stream_hasher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha384_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha384_pkg::rsp_type rsp_data
);

   sha384_pkg::cmd_type    cmd;
   sha384_pkg::status_type status;

   sha384_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .byte_valid  (req_data.byte_valid),
      .message_end (req_data.message_end),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   sha384_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_data.data_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.message_end) |=> !req_ready)
      else $error("block took an item right after a message end");

   a_block_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.byte_valid
       && status.fill == sha384_pkg::FILL_LAST) |=> !req_ready)
      else $error("full block did not start compression");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.init, cmd.round, cmd.add, cmd.emit}))
      else $error("conflicting datapath commands");

   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (cmd.emit && cmd.last && status.fill == 7'd0))
      else $error("state cleared outside the last digest word");

endmodule
